// File: sv/psva_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the point source visibility accumulator.
// Depends on nothing; every other file of the block but psva_mem imports it.
package psva_pkg;

	localparam int CELLS_DEF = 256;
	localparam int CELL_W    = 8;
	localparam int CPLX_W    = 64;
	localparam int PART_W    = 32;
	localparam int NORM_W    = 16;
	localparam int FACT_W    = 32;
	localparam int OP_W      = 33;
	localparam int PROD_W    = 2 * OP_W;
	localparam int ACC_W     = 40;
	localparam int SH_FINE   = 29;
	localparam int SH_COARSE = 10;
	localparam int STEP_W    = 5;
	localparam int LANES     = 4;
	localparam int ENTRY_W   = LANES * CPLX_W + 1;
	localparam int IN_W      = CELL_W + 9 * CPLX_W + NORM_W;
	localparam int OUT_W     = CELL_W + LANES * CPLX_W;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RECIP, ST_BRI, ST_GAP1, ST_SF, ST_GAP2, ST_VIS, ST_READ, ST_WB
	} state_t;

	typedef enum logic [1:0] {DST_BRI, DST_SF, DST_VIS} dst_t;

	typedef struct packed {
		logic              valid;
		logic              neg;
		logic              coarse;
		logic              last;
		dst_t              dst;
		logic [STEP_W-1:0] tag;
	} mac_op_t;

	typedef struct packed {
		logic [PART_W-1:0] val;
		logic              ovf;
	} sat_t;

	function automatic sat_t sat32(input logic signed [ACC_W-1:0] x);
		sat_t s;
		s.val = x[PART_W-1:0];
		s.ovf = 1'b0;
		if (x > SAT_MAX) begin
			s.val = 32'h7fff_ffff;
			s.ovf = 1'b1;
		end else if (x < SAT_MIN) begin
			s.val = 32'h8000_0000;
			s.ovf = 1'b1;
		end
		return s;
	endfunction

	// reduce an 8-bit cell number modulo the cell count, one bit per compare-subtract step
	function automatic logic [16:0] mod_cells(input logic [CELL_W-1:0] x, input int unsigned m);
		logic [17:0] r;
		r = '0;
		for (int i = CELL_W - 1; i >= 0; i--) begin
			r = {r[16:0], x[i]};
			if (r >= 18'(m))
				r = r - 18'(m);
		end
		return r[16:0];
	endfunction

endpackage

// File: sv/point_source_visibility_accumulator.sv
`timescale 1ns / 1ps
// Top level of the point source visibility accumulator: sequencer, operand registers, writeback.
// Depends on psva_pkg, psva_recip, psva_mac and psva_mem.
//
// Usage:
//   Input stream (s_axis_*): one transfer per source contribution for one cell; tlast marks
//   the final source of that cell. Output stream (m_axis_*): one transfer per finished cell
//   carrying its four saturated visibility sums; tuser flags any saturation in that cell.
//   Per-cell sums live in one memory of CELLS entries, read once and written once per item.
//   Sequence: an item runs from transfer to memory writeback through the bit-serial
//   reciprocal (32 quotient bits and a done strobe), then 68 products through a single
//   shared multiplier (4 Stokes scalings, 32 for B times conj(R), 32 for L times that)
//   with the gap states GAP1 and GAP2 between the groups, then a memory read state and a
//   read-modify-write state. A finished cell shows on the output the cycle after writeback.
//   The next transfer is taken the cycle after writeback, so the block takes no new item
//   until the last one is written back.
//   Reset: once arst_n is released the block sweeps all CELLS memory entries to zero, one
//   entry per cycle; s_axis_tready stays low during that sweep.
//   Stall: the result sits in an output register; a stalled receiver blocks the block only
//   when a further cell finishes while the previous result has not yet been taken.
module point_source_visibility_accumulator import psva_pkg::*; #(
	parameter int CELLS = CELLS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// cell_req, left_j11, left_j12, left_j21, left_j22, right_j11, right_j12,
	// right_j21, right_j22, stokes, norm
	input  logic [IN_W-1:0]  s_axis_tdata,
	input  logic             s_axis_tlast,   // last_source
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,   // cell_out, sum_xx, sum_xy, sum_yx, sum_yy
	output logic             m_axis_tuser    // overflow
);

	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	state_t state_q, state_d;

	logic [STEP_W-1:0] step_q;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CELL_W-1:0] cell_q;
	logic              last_q;
	logic [CPLX_W-1:0] stokes_q;
	logic [CPLX_W-1:0] l_q [LANES];
	logic [CPLX_W-1:0] r_q [LANES];
	logic [PART_W-1:0] b_re_q [LANES];
	logic [PART_W-1:0] b_im_q [LANES];
	logic [PART_W-1:0] sf_re_q [LANES];
	logic [PART_W-1:0] sf_im_q [LANES];
	logic signed [ACC_W-1:0] vis_re_q [LANES];
	logic signed [ACC_W-1:0] vis_im_q [LANES];
	logic              flag_q;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              out_ovf_q;

	// control outputs of the sequencer
	logic              accept;
	logic              recip_start;
	logic              mem_re;
	logic              mem_we;
	logic              wb_go;
	logic              emit;

	logic              recip_done;
	logic [FACT_W-1:0] fact;

	mac_op_t                 op;
	mac_op_t                 res_op;
	logic signed [OP_W-1:0]  op_a, op_b;
	logic signed [ACC_W-1:0] res;

	logic [ENTRY_W-1:0] rd_entry;
	logic [ENTRY_W-1:0] new_entry;
	logic [ENTRY_W-1:0] wr_entry;
	logic [IDX_W-1:0]   wr_addr;
	logic               wb_ovf;

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == IDX_W'(CELLS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (s_axis_tvalid) state_d = ST_RECIP;
			ST_RECIP: if (recip_done) state_d = ST_BRI;
			ST_BRI:   if (step_q == STEP_W'(3)) state_d = ST_GAP1;
			ST_GAP1:  state_d = ST_SF;
			ST_SF:    if (step_q == '1) state_d = ST_GAP2;
			ST_GAP2:  state_d = ST_VIS;
			ST_VIS:   if (step_q == '1) state_d = ST_READ;
			ST_READ:  state_d = ST_WB;
			ST_WB:    if (wb_go) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		accept        = s_axis_tready & s_axis_tvalid;
		recip_start   = accept;
		mem_re        = (state_q == ST_READ);
		// hold writeback while a finished cell would overwrite an untaken result
		wb_go         = (state_q == ST_WB) & ~(last_q & out_valid_q & ~m_axis_tready);
		emit          = wb_go & last_q;
		mem_we        = (state_q == ST_CLEAR) | wb_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_BRI || state_q == ST_SF || state_q == ST_VIS)
				step_q <= step_q + STEP_W'(1);
			else
				step_q <= '0;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + IDX_W'(1);
		end
	end

	// ---------------------------------------------------------------- input capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_q   <= s_axis_tdata[CELL_W-1:0];
			idx_q    <= IDX_W'(mod_cells(s_axis_tdata[CELL_W-1:0], CELLS));
			last_q   <= s_axis_tlast;
			stokes_q <= s_axis_tdata[CELL_W + 8*CPLX_W +: CPLX_W];
			for (int i = 0; i < LANES; i++) begin
				l_q[i] <= s_axis_tdata[CELL_W + i*CPLX_W +: CPLX_W];
				r_q[i] <= s_axis_tdata[CELL_W + (LANES + i)*CPLX_W +: CPLX_W];
			end
		end
	end

	psva_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (recip_start),
		.norm   (s_axis_tdata[IN_W-1 -: NORM_W]),
		.done   (recip_done),
		.fact   (fact)
	);

	// ---------------------------------------------------------------- operand select
	// step bits: [4:3] matrix entry (row, column), [2] imaginary part, [1] inner index, [0] term
	logic [1:0]        ent;
	logic              part_im, kk, sub;
	logic [PART_W-1:0] x_re, x_im, y_re, y_im, pa, pb;
	logic signed [OP_W-1:0] st_i, st_q, st_u, st_v;

	always_comb begin
		ent     = step_q[4:3];
		part_im = step_q[2];
		kk      = step_q[1];
		sub     = step_q[0];
		st_i    = OP_W'($signed(stokes_q[63:48]));
		st_q    = OP_W'($signed(stokes_q[47:32]));
		st_u    = OP_W'($signed(stokes_q[31:16]));
		st_v    = OP_W'($signed(stokes_q[15:0]));
		x_re = '0;
		x_im = '0;
		y_re = '0;
		y_im = '0;
		op   = '0;
		op.tag  = step_q;
		op.last = sub & kk;
		op_a = '0;
		op_b = '0;
		pa   = '0;
		pb   = '0;
		unique case (state_q)
			ST_BRI: begin
				op.valid  = 1'b1;
				op.coarse = 1'b1;
				op.last   = 1'b1;
				op.dst    = DST_BRI;
				op_b      = $signed({1'b0, fact});
				case (step_q[1:0])
					2'd0:    op_a = st_i + st_q;
					2'd1:    op_a = st_i - st_q;
					2'd2:    op_a = st_u;
					default: op_a = st_v;
				endcase
			end
			ST_SF: begin
				// B times conj(R): x = B[row, k], y = R[col, k]
				op.valid = 1'b1;
				op.dst   = DST_SF;
				x_re = b_re_q[{ent[1], kk}];
				x_im = b_im_q[{ent[1], kk}];
				y_re = r_q[{ent[0], kk}][CPLX_W-1 -: PART_W];
				y_im = r_q[{ent[0], kk}][PART_W-1:0];
				if (!part_im) begin
					pa = sub ? x_im : x_re;
					pb = sub ? y_im : y_re;
				end else begin
					pa     = sub ? x_re : x_im;
					pb     = sub ? y_im : y_re;
					op.neg = sub;
				end
				op_a = OP_W'($signed(pa));
				op_b = OP_W'($signed(pb));
			end
			ST_VIS: begin
				// L times SF: x = L[row, k], y = SF[k, col]
				op.valid = 1'b1;
				op.dst   = DST_VIS;
				x_re = l_q[{ent[1], kk}][CPLX_W-1 -: PART_W];
				x_im = l_q[{ent[1], kk}][PART_W-1:0];
				y_re = sf_re_q[{kk, ent[0]}];
				y_im = sf_im_q[{kk, ent[0]}];
				if (!part_im) begin
					pa     = sub ? x_im : x_re;
					pb     = sub ? y_im : y_re;
					op.neg = sub;
				end else begin
					pa = sub ? x_im : x_re;
					pb = sub ? y_re : y_im;
				end
				op_a = OP_W'($signed(pa));
				op_b = OP_W'($signed(pb));
			end
			default: op.valid = 1'b0;
		endcase
	end

	psva_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.a      (op_a),
		.b      (op_b),
		.res_op (res_op),
		.res    (res)
	);

	// ---------------------------------------------------------------- group results
	sat_t res_sat;
	sat_t neg_sat;

	always_comb begin
		res_sat = sat32(res);
		neg_sat = sat32(-ACC_W'($signed(res_sat.val)));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flag_q    <= 1'b0;
			b_im_q[0] <= '0;
			b_im_q[3] <= '0;
		end else if (res_op.valid) begin
			case (res_op.dst)
				DST_BRI: begin
					// the V scaling also saturates on its negation for s3
					flag_q <= flag_q | res_sat.ovf | ((res_op.tag[1:0] == 2'd3) & neg_sat.ovf);
					case (res_op.tag[1:0])
						2'd0: b_re_q[0] <= res_sat.val;
						2'd1: b_re_q[3] <= res_sat.val;
						2'd2: begin
							b_re_q[1] <= res_sat.val;
							b_re_q[2] <= res_sat.val;
						end
						default: begin
							// s3 is conj(s2): negate the imaginary part with saturation
							b_im_q[1] <= res_sat.val;
							b_im_q[2] <= neg_sat.val;
						end
					endcase
				end
				DST_SF: begin
					flag_q <= flag_q | res_sat.ovf;
					if (res_op.tag[2])
						sf_im_q[res_op.tag[4:3]] <= res_sat.val;
					else
						sf_re_q[res_op.tag[4:3]] <= res_sat.val;
				end
				DST_VIS: begin
					// contributions stay unsaturated until they meet the stored sum
					if (res_op.tag[2])
						vis_im_q[res_op.tag[4:3]] <= res;
					else
						vis_re_q[res_op.tag[4:3]] <= res;
				end
				default: flag_q <= flag_q;
			endcase
		end
	end

	// ---------------------------------------------------------------- memory update
	sat_t lane_re [LANES];
	sat_t lane_im [LANES];

	always_comb begin
		wb_ovf = rd_entry[ENTRY_W-1] | flag_q;
		for (int v = 0; v < LANES; v++) begin
			lane_re[v] = sat32(ACC_W'($signed(rd_entry[v*CPLX_W + PART_W +: PART_W]))
				+ vis_re_q[v]);
			lane_im[v] = sat32(ACC_W'($signed(rd_entry[v*CPLX_W +: PART_W])) + vis_im_q[v]);
			wb_ovf     = wb_ovf | lane_re[v].ovf | lane_im[v].ovf;
		end
		new_entry[ENTRY_W-1] = wb_ovf;
		for (int v = 0; v < LANES; v++)
			new_entry[v*CPLX_W +: CPLX_W] = {lane_re[v].val, lane_im[v].val};
		// clear the cell once its sums leave the block
		if (state_q == ST_CLEAR || last_q)
			wr_entry = '0;
		else
			wr_entry = new_entry;
		wr_addr = (state_q == ST_CLEAR) ? clr_q : idx_q;
	end

	psva_mem #(
		.DEPTH (CELLS),
		.IDX_W (IDX_W),
		.WIDTH (ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.re    (mem_re),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= {new_entry[LANES*CPLX_W-1:0], cell_q};
			out_ovf_q  <= wb_ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ovf_q;

`ifndef NO_ASSERTIONS
	// multiplier group results only land while the product sequence runs or drains
	assert property (@(posedge clk) disable iff (!arst_n)
		res_op.valid |-> (state_q == ST_BRI || state_q == ST_GAP1 || state_q == ST_SF ||
			state_q == ST_GAP2 || state_q == ST_VIS || state_q == ST_READ))
		else $error("mac result outside product sequence");

	// the reciprocal finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		recip_done |-> state_q == ST_RECIP)
		else $error("reciprocal done in wrong state");

	// a finished cell shows up on the output in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_axis_tvalid)
		else $error("emitted cell missing on output");

	// no memory write outside the clearing sweep and writeback
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_WB))
		else $error("unexpected memory write");
`endif

endmodule

// File: sv/psva_recip.sv
`timescale 1ns / 1ps
// Iterative reciprocal unit: fact = floor(2^31 / norm), one quotient bit per cycle.
// Depends on psva_pkg.
module psva_recip import psva_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NORM_W-1:0] norm,
	output logic              done,
	output logic [FACT_W-1:0] fact
);

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [NORM_W-1:0] rem_q;
	logic [NORM_W-1:0] den_q;
	logic [FACT_W-1:0] quo_q;
	logic [NORM_W:0]   trial;
	logic              ge;

	// the dividend 2^31 has a single one, in its top bit
	// a zero divisor makes every trial succeed, so the quotient saturates to all ones
	always_comb begin
		trial = {rem_q, (cnt_q == 5'd31)};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= norm;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? NORM_W'(trial - {1'b0, den_q}) : trial[NORM_W-1:0];
			quo_q <= {quo_q[FACT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign fact = quo_q;

endmodule

// File: sv/psva_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: registered 33x33 product, then shift and sum of a term group.
// Depends on psva_pkg.
module psva_mac import psva_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_op_t                 op,
	input  logic signed [OP_W-1:0]  a,
	input  logic signed [OP_W-1:0]  b,
	output mac_op_t                 res_op,
	output logic signed [ACC_W-1:0] res
);

	mac_op_t                  op_s1;
	logic signed [PROD_W-1:0] p_s1;
	logic signed [PROD_W-1:0] term;
	logic signed [ACC_W-1:0]  term_n;
	logic signed [ACC_W-1:0]  sum;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			op_s1 <= '0;
		else
			op_s1 <= op;
	end

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

	// each product is shifted on its own, flooring, before it joins the group sum
	always_comb begin
		term   = op_s1.coarse ? (p_s1 >>> SH_COARSE) : (p_s1 >>> SH_FINE);
		term_n = op_s1.neg ? -term[ACC_W-1:0] : term[ACC_W-1:0];
		sum    = acc_q + term_n;
		res    = sum;
		res_op = op_s1;
		res_op.valid = op_s1.valid & op_s1.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_q <= '0;
		else if (op_s1.valid)
			acc_q <= op_s1.last ? '0 : sum;
	end

endmodule

// File: sv/psva_mem.sv
`timescale 1ns / 1ps
// Simple dual-port cell memory, one write and one registered read per cycle.
// Depends on nothing.
module psva_mem #(
	parameter int DEPTH = 256,
	parameter int IDX_W = 8,
	parameter int WIDTH = 257
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: dv/tb_point_source_visibility_accumulator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the point source visibility accumulator.
// Depends on psva_pkg and the block; predicts each cell's sums and compares every output transfer.
module tb_point_source_visibility_accumulator;
	import psva_pkg::*;

	localparam int WATCHDOG = 20000;

	typedef struct {
		logic [7:0]  cell_id;
		logic [63:0] xx, xy, yx, yy;
		logic        ovf;
	} vis_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	// predicted per-cell state
	logic [63:0] sum_xx_mdl [CELLS_DEF];
	logic [63:0] sum_xy_mdl [CELLS_DEF];
	logic [63:0] sum_yx_mdl [CELLS_DEF];
	logic [63:0] sum_yy_mdl [CELLS_DEF];
	logic        ovf_mdl    [CELLS_DEF];

	vis_t pending_vis[$];
	int   errors = 0;
	int   idle_cycles = 0;
	int   src_gap_pct = 0;
	int   snk_stall_pct = 0;

	point_source_visibility_accumulator DUT (.*);

	initial forever #5 clk = ~clk;

	// floor shift of a product
	function automatic longint prod29(longint a, longint b);
		return (a * b) >>> 29;
	endfunction

	function automatic longint sat(longint v, inout bit f);
		if (v > 64'sd2147483647) begin f = 1; return 64'sd2147483647; end
		if (v < -64'sd2147483648) begin f = 1; return -64'sd2147483648; end
		return v;
	endfunction

	function automatic longint re_of(logic [63:0] x);
		return longint'(signed'(x[63:32]));
	endfunction

	function automatic longint im_of(logic [63:0] x);
		return longint'(signed'(x[31:0]));
	endfunction

	// add a contribution into a packed accumulator with saturation
	function automatic logic [63:0] acc_add(logic [63:0] a, longint cr, longint ci, inout bit f);
		longint r, i;
		r = sat(re_of(a) + cr, f);
		i = sat(im_of(a) + ci, f);
		return {r[31:0], i[31:0]};
	endfunction

	task automatic predict_source(input logic [IN_W-1:0] d, input logic last);
		logic [7:0] cell_id;
		longint lr[4], li[4], rr[4], ri[4];
		longint si, sq, su, sv, fct, n;
		longint br[4], bi[4], fr[4], fi[4], cr, ci;
		bit f;
		int k;
		vis_t v;
		f = 0;
		cell_id = d[7:0];
		for (k = 0; k < 4; k++) begin
			lr[k] = re_of(d[8 + 64*k +: 64]);
			li[k] = im_of(d[8 + 64*k +: 64]);
			rr[k] = re_of(d[264 + 64*k +: 64]);
			ri[k] = im_of(d[264 + 64*k +: 64]);
		end
		si = longint'(signed'(d[520+48 +: 16]));
		sq = longint'(signed'(d[520+32 +: 16]));
		su = longint'(signed'(d[520+16 +: 16]));
		sv = longint'(signed'(d[520 +: 16]));
		n = longint'(d[584 +: 16]);
		fct = (n == 0) ? 64'hFFFF_FFFF : (64'sd2147483648 / n);
		// brightness: b0=s1, b1=s2, b2=s3, b3=s4
		br[0] = sat(((si + sq) * fct) >>> 10, f); bi[0] = 0;
		br[3] = sat(((si - sq) * fct) >>> 10, f); bi[3] = 0;
		br[1] = sat((su * fct) >>> 10, f);
		bi[1] = sat((sv * fct) >>> 10, f);
		br[2] = br[1];
		bi[2] = sat(-bi[1], f);
		// sf = B * R^H; row r, col c uses b[2r], b[2r+1] and R row c
		for (k = 0; k < 4; k++) begin
			int r, c;
			r = k / 2; c = k % 2;
			fr[k] = sat(prod29(br[2*r], rr[2*c]) + prod29(bi[2*r], ri[2*c])
				+ prod29(br[2*r+1], rr[2*c+1]) + prod29(bi[2*r+1], ri[2*c+1]), f);
			fi[k] = sat(prod29(bi[2*r], rr[2*c]) - prod29(br[2*r], ri[2*c])
				+ prod29(bi[2*r+1], rr[2*c+1]) - prod29(br[2*r+1], ri[2*c+1]), f);
		end
		for (k = 0; k < 4; k++) begin
			int r, c;
			r = k / 2; c = k % 2;
			cr = prod29(lr[2*r], fr[c]) - prod29(li[2*r], fi[c])
				+ prod29(lr[2*r+1], fr[2+c]) - prod29(li[2*r+1], fi[2+c]);
			ci = prod29(lr[2*r], fi[c]) + prod29(li[2*r], fr[c])
				+ prod29(lr[2*r+1], fi[2+c]) + prod29(li[2*r+1], fr[2+c]);
			case (k)
				0: sum_xx_mdl[cell_id] = acc_add(sum_xx_mdl[cell_id], cr, ci, f);
				1: sum_xy_mdl[cell_id] = acc_add(sum_xy_mdl[cell_id], cr, ci, f);
				2: sum_yx_mdl[cell_id] = acc_add(sum_yx_mdl[cell_id], cr, ci, f);
				default: sum_yy_mdl[cell_id] = acc_add(sum_yy_mdl[cell_id], cr, ci, f);
			endcase
		end
		if (f) ovf_mdl[cell_id] = 1'b1;
		if (last) begin
			v.cell_id = cell_id; v.xx = sum_xx_mdl[cell_id]; v.xy = sum_xy_mdl[cell_id];
			v.yx = sum_yx_mdl[cell_id]; v.yy = sum_yy_mdl[cell_id]; v.ovf = ovf_mdl[cell_id];
			pending_vis.push_back(v);
			sum_xx_mdl[cell_id] = '0; sum_xy_mdl[cell_id] = '0;
			sum_yx_mdl[cell_id] = '0; sum_yy_mdl[cell_id] = '0; ovf_mdl[cell_id] = 1'b0;
		end
	endtask

	// send one source contribution; hold valid until the transfer
	// valid drops only in an idle cycle or when the test drains
	task automatic send_source(input logic [7:0] cell_id, input logic [63:0] lj[4],
			input logic [63:0] rj[4], input logic [63:0] stokes, input logic [15:0] norm,
			input logic last);
		logic [IN_W-1:0] d;
		int k;
		d[7:0] = cell_id;
		for (k = 0; k < 4; k++) begin
			d[8 + 64*k +: 64] = lj[k];
			d[264 + 64*k +: 64] = rj[k];
		end
		d[520 +: 64] = stokes;
		d[584 +: 16] = norm;
		while ($urandom_range(99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_source(d, last);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// Jones value with moderate magnitude, always within +-1.0, well inside Q2.29
	function automatic logic [63:0] jones_mild();
		logic [31:0] r, i;
		r = 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
		i = 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
		return {r, i};
	endfunction

	task automatic random_source(input logic [7:0] cell_id, input logic last, input bit wild);
		logic [63:0] lj[4], rj[4];
		int k;
		for (k = 0; k < 4; k++) begin
			lj[k] = wild ? rnd64() : jones_mild();
			rj[k] = wild ? rnd64() : jones_mild();
		end
		send_source(cell_id, lj, rj, rnd64(),
			wild ? 16'($urandom) : 16'($urandom_range(16'h0080, 16'hFFFF)), last);
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_vis.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// extremes: zero norm, max fields, all-ones, cell extremes
	task automatic test_directed();
		logic [63:0] lj[4], rj[4];
		int k;
		for (k = 0; k < 4; k++) begin lj[k] = {32'h2000_0000, 32'h0}; rj[k] = lj[k]; end
		send_source(8'd0, lj, rj, {16'h0080, 16'h0000, 16'h0000, 16'h0000}, 16'h0100, 1'b1);
		send_source(8'd255, lj, rj, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h0000, 1'b1);
		send_source(8'd1, lj, rj, {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h0001, 1'b0);
		send_source(8'd1, lj, rj, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'hFFFF, 1'b1);
		for (k = 0; k < 4; k++) begin lj[k] = '1; rj[k] = '0; end
		send_source(8'd128, lj, rj, '1, 16'hFFFF, 1'b1);
		for (k = 0; k < 4; k++) begin lj[k] = 64'h7FFF_FFFF_8000_0000; rj[k] = lj[k]; end
		send_source(8'd127, lj, rj, 64'h7FFF_8000_7FFF_8000, 16'h0001, 1'b0);
		send_source(8'd127, lj, rj, 64'h7FFF_8000_7FFF_8000, 16'h0001, 1'b1);
		for (k = 0; k < 4; k++) begin lj[k] = 64'h8000_0000_7FFF_FFFF; rj[k] = '1; end
		send_source(8'd2, lj, rj, 64'h8000_7FFF_8000_7FFF, 16'h0000, 1'b1);
		// same cell accumulates across several sources, cleared after emit
		repeat (4) random_source(8'd3, 1'b0, 1'b0);
		random_source(8'd3, 1'b1, 1'b0);
		random_source(8'd3, 1'b1, 1'b0);
		for (k = 0; k < 6; k++) random_source(8'($urandom), 1'b1, 1'b1);
		wait_drain();
	endtask

	// interleaved cells, mostly well-formed runs, some noise
	task automatic test_random(input int count);
		int k;
		logic [7:0] hot[4];
		for (k = 0; k < 4; k++) hot[k] = 8'($urandom);
		for (k = 0; k < count; k++) begin
			int j;
			j = $urandom_range(3);
			if ($urandom_range(9) == 0) hot[j] = 8'($urandom);
			random_source($urandom_range(9) == 0 ? 8'($urandom) : hot[j],
				$urandom_range(3) == 0, $urandom_range(4) == 0);
		end
		wait_drain();
	endtask

	// output checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			vis_t e;
			if (pending_vis.size() == 0) begin
				$error("unexpected output transfer, cell %0d", m_axis_tdata[7:0]);
				errors++;
			end else begin
				e = pending_vis.pop_front();
				if (m_axis_tdata[7:0] !== e.cell_id) begin
					$error("cell_out exp %h got %h", e.cell_id, m_axis_tdata[7:0]); errors++;
				end
				if (m_axis_tdata[8 +: 64] !== e.xx) begin
					$error("sum_xx exp %h got %h", e.xx, m_axis_tdata[8 +: 64]); errors++;
				end
				if (m_axis_tdata[72 +: 64] !== e.xy) begin
					$error("sum_xy exp %h got %h", e.xy, m_axis_tdata[72 +: 64]); errors++;
				end
				if (m_axis_tdata[136 +: 64] !== e.yx) begin
					$error("sum_yx exp %h got %h", e.yx, m_axis_tdata[136 +: 64]); errors++;
				end
				if (m_axis_tdata[200 +: 64] !== e.yy) begin
					$error("sum_yy exp %h got %h", e.yy, m_axis_tdata[200 +: 64]); errors++;
				end
				if (m_axis_tuser !== e.ovf) begin
					$error("overflow exp %b got %b", e.ovf, m_axis_tuser); errors++;
				end
			end
		end
	end

	// receiver stall and watchdog
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		for (int c = 0; c < CELLS_DEF; c++) begin
			sum_xx_mdl[c] = '0; sum_xy_mdl[c] = '0; sum_yx_mdl[c] = '0;
			sum_yy_mdl[c] = '0; ovf_mdl[c] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_gap_pct = 34; snk_stall_pct = 59;
		test_directed();
		test_random(560);
		src_gap_pct = 59; snk_stall_pct = 34;
		test_random(560);
		src_gap_pct = 0; snk_stall_pct = 0;
		test_random(600);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
sv/psva_pkg.sv
sv/psva_recip.sv
sv/psva_mac.sv
sv/psva_mem.sv
sv/point_source_visibility_accumulator.sv
dv/tb_point_source_visibility_accumulator.sv
